[rtl/masp_pkg.sv]
// ----------------------------------------------------------------------------
// Masked axis spread package
// Shared widths, register and axis codes, and the record passed from the
// accumulating front end to the arithmetic back end.
// ----------------------------------------------------------------------------
package masp_pkg;

  localparam int MAX_EDGE_DEF   = 256;
  localparam int VALUE_BITS_DEF = 24;
  localparam int QUEUE_DEPTH    = 2;

  localparam int SIZE_W   = 9;
  localparam int AXIS_W   = 2;
  localparam int MASS_W   = 48;
  localparam int FIRST_W  = 56;
  localparam int SECOND_W = 64;
  localparam int SPREAD_W = 48;
  localparam int OUT_FRAC = 24;
  localparam int WIDE_W   = 128;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(64);

  localparam logic [SPREAD_W-1:0] SPREAD_BAD = ~((SPREAD_W'(1) << OUT_FRAC) - SPREAD_W'(1));

  typedef enum logic [1:0] {
    CFG_SIZE_I = 2'd0,
    CFG_SIZE_J = 2'd1,
    CFG_SIZE_K = 2'd2,
    CFG_AXIS   = 2'd3
  } cfg_reg_t;

  typedef enum logic [AXIS_W-1:0] {
    AXIS_I   = 2'd0,
    AXIS_J   = 2'd1,
    AXIS_K   = 2'd2,
    AXIS_BAD = 2'd3
  } axis_t;

  typedef struct packed {
    logic                bad;
    logic [MASS_W-1:0]   mass;
    logic [FIRST_W-1:0]  first;
    logic [SECOND_W-1:0] second;
  } grid_sums_t;

endpackage

[rtl/masked_axis_spread_unit.sv]
// ----------------------------------------------------------------------------
// Masked axis spread unit
// Nodes are taken one per cycle while the two-entry queue has room; the back
// end runs three 64-step multiplies and 152 divide steps per grid.
// A grid with an unrecognized axis or a total that is not positive skips
// the multiplies and the divide and goes straight to its result beat.
// Synchronous reset clears counters, sums, queue and control; sizes reset to 64.
// ----------------------------------------------------------------------------
module masked_axis_spread_unit #(
  parameter int MAX_EDGE   = masp_pkg::MAX_EDGE_DEF,
  parameter int VALUE_BITS = masp_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [1:0]                          cfg_index,
  input  logic [masp_pkg::SIZE_W-1:0]         cfg_data,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // node_value, zero padding up to a whole byte
  input  logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  // is_solid
  input  logic [0:0]                          s_axis_tuser,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // spread
  output logic [masp_pkg::SPREAD_W-1:0]       m_axis_tdata,
  // bad_axis, no_mass
  output logic [1:0]                          m_axis_tuser
);
  import masp_pkg::*;

  grid_sums_t push_data, head;
  logic       push, pop, q_full, q_empty;
  logic       bad_axis, no_mass;

  assign cfg_ready = 1'b1;

  masp_front #(
    .MAX_EDGE   (MAX_EDGE),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .node_value (s_axis_tdata[VALUE_BITS-1:0]),
    .is_solid   (s_axis_tuser[0]),
    .last_node  (s_axis_tlast),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  masp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  masp_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .spread    (m_axis_tdata),
    .bad_axis  (bad_axis),
    .no_mass   (no_mass)
  );

  assign m_axis_tuser = {no_mass, bad_axis};

endmodule

[rtl/masp_front.sv]
// ----------------------------------------------------------------------------
// Masked axis spread front end
// Holds the configuration, walks the raster counters and accumulates the
// three sums; pushes the finished sums of a grid into the queue.
// ----------------------------------------------------------------------------
module masp_front #(
  parameter int MAX_EDGE   = masp_pkg::MAX_EDGE_DEF,
  parameter int VALUE_BITS = masp_pkg::VALUE_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic [1:0]                 cfg_index,
  input  logic [masp_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [VALUE_BITS-1:0]      node_value,
  input  logic                       is_solid,
  input  logic                       last_node,
  input  logic                       q_full,
  output logic                       push,
  output masp_pkg::grid_sums_t       push_data
);
  import masp_pkg::*;

  localparam int POS_W = (MAX_EDGE > 1) ? $clog2(MAX_EDGE) : 1;
  localparam int CNT_W = POS_W + 1;
  localparam int SQ_W  = 2 * POS_W;
  localparam int P1_W  = VALUE_BITS + POS_W + 1;
  localparam int P2_W  = VALUE_BITS + SQ_W + 1;

  logic [SIZE_W-1:0] size_i, size_j, size_k;
  logic [AXIS_W-1:0] axis_sel;
  logic [POS_W-1:0]  pos_i, pos_j, pos_k;
  logic [SQ_W-1:0]   sq_i, sq_j, sq_k;
  logic [MASS_W-1:0]   mass_sum, mass_sum_next;
  logic [FIRST_W-1:0]  first_moment, first_moment_next;
  logic [SECOND_W-1:0] second_moment, second_moment_next;

  logic [POS_W-1:0] pos_i_next, pos_j_next, pos_k_next, pos_sel;
  logic [SQ_W-1:0]  sq_i_next, sq_j_next, sq_k_next, sq_sel;
  logic [CNT_W-1:0] inc_i, inc_j, inc_k;
  logic             wrap_i, wrap_j, wrap_k;
  logic             accept;
  logic signed [VALUE_BITS-1:0] v;
  logic signed [P1_W-1:0] prod1;
  logic signed [P2_W-1:0] prod2;

  function automatic logic [CNT_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    if (s == '0) return CNT_W'(1);
    if (int'(s) > MAX_EDGE) return CNT_W'(MAX_EDGE);
    return CNT_W'(s);
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign v        = $signed(node_value);

  always_comb begin
    case (axis_sel)
      AXIS_I: begin
        pos_sel = pos_i;
        sq_sel  = sq_i;
      end
      AXIS_J: begin
        pos_sel = pos_j;
        sq_sel  = sq_j;
      end
      AXIS_K: begin
        pos_sel = pos_k;
        sq_sel  = sq_k;
      end
      default: begin
        pos_sel = '0;
        sq_sel  = '0;
      end
    endcase

    prod1 = P1_W'(v) * P1_W'($signed({1'b0, pos_sel}));
    prod2 = P2_W'(v) * P2_W'($signed({1'b0, sq_sel}));

    mass_sum_next      = mass_sum;
    first_moment_next  = first_moment;
    second_moment_next = second_moment;
    if (!is_solid) begin
      mass_sum_next      = mass_sum + {{(MASS_W-VALUE_BITS){v[VALUE_BITS-1]}}, v};
      first_moment_next  = first_moment + {{(FIRST_W-P1_W){prod1[P1_W-1]}}, prod1};
      second_moment_next = second_moment + {{(SECOND_W-P2_W){prod2[P2_W-1]}}, prod2};
    end

    inc_k  = {1'b0, pos_k} + CNT_W'(1);
    wrap_k = inc_k >= eff_size(size_k);
    inc_j  = {1'b0, pos_j} + CNT_W'(1);
    wrap_j = inc_j >= eff_size(size_j);
    inc_i  = {1'b0, pos_i} + CNT_W'(1);
    wrap_i = inc_i >= eff_size(size_i);

    pos_k_next = wrap_k ? '0 : inc_k[POS_W-1:0];
    sq_k_next  = wrap_k ? '0 : sq_k + SQ_W'({pos_k, 1'b0}) + SQ_W'(1);
    pos_j_next = pos_j;
    sq_j_next  = sq_j;
    pos_i_next = pos_i;
    sq_i_next  = sq_i;
    if (wrap_k) begin
      pos_j_next = wrap_j ? '0 : inc_j[POS_W-1:0];
      sq_j_next  = wrap_j ? '0 : sq_j + SQ_W'({pos_j, 1'b0}) + SQ_W'(1);
      if (wrap_j) begin
        pos_i_next = wrap_i ? '0 : inc_i[POS_W-1:0];
        sq_i_next  = wrap_i ? '0 : sq_i + SQ_W'({pos_i, 1'b0}) + SQ_W'(1);
      end
    end
  end

  assign push             = accept && last_node;
  assign push_data.bad    = (axis_sel == AXIS_BAD);
  assign push_data.mass   = mass_sum_next;
  assign push_data.first  = first_moment_next;
  assign push_data.second = second_moment_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_i        <= SIZE_RESET;
      size_j        <= SIZE_RESET;
      size_k        <= SIZE_RESET;
      axis_sel      <= AXIS_I;
      pos_i         <= '0;
      pos_j         <= '0;
      pos_k         <= '0;
      sq_i          <= '0;
      sq_j          <= '0;
      sq_k          <= '0;
      mass_sum      <= '0;
      first_moment  <= '0;
      second_moment <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_SIZE_I: size_i <= cfg_data;
          CFG_SIZE_J: size_j <= cfg_data;
          CFG_SIZE_K: size_k <= cfg_data;
          CFG_AXIS:   axis_sel <= cfg_data[AXIS_W-1:0];
          default:    axis_sel <= axis_sel;
        endcase
      end
      if (accept) begin
        if (last_node) begin
          pos_i         <= '0;
          pos_j         <= '0;
          pos_k         <= '0;
          sq_i          <= '0;
          sq_j          <= '0;
          sq_k          <= '0;
          mass_sum      <= '0;
          first_moment  <= '0;
          second_moment <= '0;
        end else begin
          pos_i         <= pos_i_next;
          pos_j         <= pos_j_next;
          pos_k         <= pos_k_next;
          sq_i          <= sq_i_next;
          sq_j          <= sq_j_next;
          sq_k          <= sq_k_next;
          mass_sum      <= mass_sum_next;
          first_moment  <= first_moment_next;
          second_moment <= second_moment_next;
        end
      end
    end
  end

endmodule

[rtl/masp_queue.sv]
// ----------------------------------------------------------------------------
// Masked axis spread queue
// Short first-in first-out buffer of per-grid sums between the front end
// and the back end.
// ----------------------------------------------------------------------------
module masp_queue #(
  parameter int DEPTH = masp_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  masp_pkg::grid_sums_t push_data,
  input  logic                 pop,
  output masp_pkg::grid_sums_t head,
  output logic                 full,
  output logic                 empty
);
  import masp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  grid_sums_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/masp_back.sv]
// ----------------------------------------------------------------------------
// Masked axis spread back end
// Turns the sums of one grid into the variance with a shared shift-add
// multiplier and a restoring divider, and holds the result beat.
// ----------------------------------------------------------------------------
module masp_back #(
  parameter int VALUE_BITS = masp_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  masp_pkg::grid_sums_t         q_data,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [masp_pkg::SPREAD_W-1:0] spread,
  output logic                         bad_axis,
  output logic                         no_mass
);
  import masp_pkg::*;

  localparam int FRAC_BITS = VALUE_BITS - 4;
  localparam int SH_UP     = (FRAC_BITS <= OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int SH_DN     = (FRAC_BITS > OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;
  localparam int MUL_STEPS = SECOND_W;
  localparam int MUL_CNT_W = $clog2(MUL_STEPS);
  localparam int DIV_STEPS = WIDE_W + OUT_FRAC;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int Q_W       = SPREAD_W + 2;

  localparam logic [63:0]    SAT_POS = (64'd1 << (SPREAD_W - 1)) - 64'd1;
  localparam logic [63:0]    SAT_NEG = 64'd1 << (SPREAD_W - 1);
  localparam logic [63:0]    BIG_Q   = 64'd1 << (SPREAD_W + 1);
  localparam logic [Q_W-1:0] Q_LIMIT = Q_W'(1) << SPREAD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_P,
    ST_MUL_Q,
    ST_MUL_D,
    ST_COMB,
    ST_FIX,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t state;

  logic [MASS_W-1:0]    m_reg;
  logic [FIRST_W-1:0]   s1_mag;
  logic                 s2_neg;
  logic [WIDE_W-1:0]    mcand, acc, p_reg, q_reg, d_reg;
  logic [SECOND_W-1:0]  mplier;
  logic [MUL_CNT_W-1:0] mul_cnt;
  logic [WIDE_W-1:0]    num, rem;
  logic [Q_W-1:0]       quo;
  logic                 big, res_neg, fix;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [SPREAD_W-1:0]  res_spread;
  logic                 res_bad, res_nm;

  logic [WIDE_W-1:0]   acc_next, rem_sh;
  logic [WIDE_W:0]     rem_diff, pq_sum;
  logic                rem_ge;
  logic [Q_W-1:0]      quo_next;
  logic [SECOND_W-1:0] s2_in_mag;
  logic [FIRST_W-1:0]  s1_in_mag;
  logic                mul_done, mass_empty;

  function automatic logic [SPREAD_W-1:0] pack_signed(input logic neg, input logic [63:0] m);
    logic [63:0] c;
    logic [63:0] nc;
    if (neg) begin
      c  = (m > SAT_NEG) ? SAT_NEG : m;
      nc = 64'd0 - c;
      return nc[SPREAD_W-1:0];
    end
    c = (m > SAT_POS) ? SAT_POS : m;
    return c[SPREAD_W-1:0];
  endfunction

  function automatic logic [SPREAD_W-1:0] raw_second(input logic [SECOND_W-1:0] s2);
    logic        neg;
    logic [63:0] a;
    logic [63:0] lim;
    neg = s2[SECOND_W-1];
    a   = neg ? 64'd0 - s2 : s2;
    lim = neg ? SAT_NEG : SAT_POS;
    if (FRAC_BITS <= OUT_FRAC) begin
      a = (a > (lim >> SH_UP)) ? lim : (a << SH_UP);
    end else begin
      a = a >> SH_DN;
    end
    return pack_signed(neg, a);
  endfunction

  always_comb begin
    pop        = (state == ST_IDLE) && !q_empty;
    s2_in_mag  = q_data.second[SECOND_W-1] ? SECOND_W'(0) - q_data.second : q_data.second;
    s1_in_mag  = q_data.first[FIRST_W-1] ? FIRST_W'(0) - q_data.first : q_data.first;
    mass_empty = q_data.mass[MASS_W-1] || (q_data.mass == '0);

    acc_next = mplier[0] ? acc + mcand : acc;
    mul_done = (mul_cnt == MUL_CNT_W'(MUL_STEPS - 1));

    pq_sum = s2_neg ? {1'b0, p_reg} + {1'b0, q_reg} : {1'b0, p_reg} - {1'b0, q_reg};

    rem_sh   = {rem[WIDE_W-2:0], num[WIDE_W-1]};
    rem_diff = {1'b0, rem_sh} - {1'b0, d_reg};
    rem_ge   = !rem_diff[WIDE_W];
    quo_next = {quo[Q_W-2:0], rem_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            m_reg   <= q_data.mass;
            s1_mag  <= s1_in_mag;
            s2_neg  <= q_data.second[SECOND_W-1];
            mcand   <= WIDE_W'(s2_in_mag);
            mplier  <= SECOND_W'(q_data.mass);
            acc     <= '0;
            mul_cnt <= '0;
            if (q_data.bad) begin
              res_spread <= SPREAD_BAD;
              res_bad    <= 1'b1;
              res_nm     <= 1'b0;
              state      <= ST_EMIT;
            end else if (mass_empty) begin
              res_spread <= raw_second(q_data.second);
              res_bad    <= 1'b0;
              res_nm     <= 1'b1;
              state      <= ST_EMIT;
            end else begin
              res_bad <= 1'b0;
              res_nm  <= 1'b0;
              state   <= ST_MUL_P;
            end
          end
        end
        ST_MUL_P, ST_MUL_Q, ST_MUL_D: begin
          if (mul_done) begin
            acc     <= '0;
            mul_cnt <= '0;
            if (state == ST_MUL_P) begin
              p_reg  <= acc_next;
              mcand  <= WIDE_W'(s1_mag);
              mplier <= SECOND_W'(s1_mag);
              state  <= ST_MUL_Q;
            end else if (state == ST_MUL_Q) begin
              q_reg  <= acc_next;
              mcand  <= WIDE_W'(m_reg);
              mplier <= SECOND_W'(m_reg);
              state  <= ST_MUL_D;
            end else begin
              d_reg <= acc_next;
              state <= ST_COMB;
            end
          end else begin
            acc     <= acc_next;
            mcand   <= mcand << 1;
            mplier  <= mplier >> 1;
            mul_cnt <= mul_cnt + MUL_CNT_W'(1);
          end
        end
        ST_COMB: begin
          num     <= pq_sum[WIDE_W-1:0];
          fix     <= !s2_neg && pq_sum[WIDE_W];
          res_neg <= s2_neg || pq_sum[WIDE_W];
          state   <= ST_FIX;
        end
        ST_FIX: begin
          if (fix) begin
            num <= WIDE_W'(0) - num;
          end
          rem     <= '0;
          quo     <= '0;
          big     <= 1'b0;
          div_cnt <= '0;
          state   <= ST_DIV;
        end
        ST_DIV: begin
          rem     <= rem_ge ? rem_diff[WIDE_W-1:0] : rem_sh;
          num     <= num << 1;
          quo     <= quo_next;
          big     <= big || (quo_next > Q_LIMIT);
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
            res_spread <= pack_signed(res_neg, (big || (quo_next > Q_LIMIT)) ?
                                               BIG_Q : 64'(quo_next));
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            spread    <= res_spread;
            bad_axis  <= res_bad;
            no_mass   <= res_nm;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[sim/masp_spread_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked axis spread checker
// Watches the register, node and result channels of the spread unit. It keeps
// its own raster counters, sums and register copies, works out the spread
// that every last node must produce, and compares result beats in order.
// ----------------------------------------------------------------------------
module masp_spread_checker (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          cfg_valid,
  input  logic                                          cfg_ready,
  input  logic [1:0]                                    cfg_index,
  input  logic [masp_pkg::SIZE_W-1:0]                   cfg_data,
  input  logic                                          s_axis_tvalid,
  input  logic                                          s_axis_tready,
  // node_value
  input  logic [((masp_pkg::VALUE_BITS_DEF+7)/8)*8-1:0] s_axis_tdata,
  // is_solid
  input  logic [0:0]                                    s_axis_tuser,
  input  logic                                          s_axis_tlast,
  input  logic                                          m_axis_tvalid,
  input  logic                                          m_axis_tready,
  // spread
  input  logic [masp_pkg::SPREAD_W-1:0]                 m_axis_tdata,
  // bad_axis, no_mass
  input  logic [1:0]                                    m_axis_tuser,
  output int                                            fails,
  output int                                            waiting,
  output int                                            checked,
  output int                                            no_mass_seen,
  output int                                            bad_axis_seen
);
  import masp_pkg::*;

  localparam int VALUE_BITS = VALUE_BITS_DEF;
  localparam int WORK_W     = 160;
  localparam logic [SPREAD_W-1:0] MINUS_ONE = -(SPREAD_W'(1) << OUT_FRAC);

  typedef struct packed {
    logic [SPREAD_W-1:0] spread;
    logic                bad_axis;
    logic                no_mass;
  } spread_result_t;

  logic [SIZE_W-1:0]   size_i;
  logic [SIZE_W-1:0]   size_j;
  logic [SIZE_W-1:0]   size_k;
  axis_t               axis_sel;
  int                  pos_i;
  int                  pos_j;
  int                  pos_k;
  logic [MASS_W-1:0]   mass_acc;
  logic [FIRST_W-1:0]  first_acc;
  logic [SECOND_W-1:0] second_acc;
  spread_result_t      spread_due[$];

  function automatic int extent(logic [SIZE_W-1:0] s);
    if (s == '0) return 1;
    if (s > MAX_EDGE_DEF) return MAX_EDGE_DEF;
    return int'(s);
  endfunction

  function automatic void clear_grid();
    pos_i      = 0;
    pos_j      = 0;
    pos_k      = 0;
    mass_acc   = '0;
    first_acc  = '0;
    second_acc = '0;
  endfunction

  function automatic logic [SPREAD_W-1:0] saturate(logic neg, logic [WORK_W-1:0] mag);
    logic [WORK_W-1:0] lim;
    lim = (WORK_W'(1) << (SPREAD_W - 1)) - (neg ? WORK_W'(0) : WORK_W'(1));
    if (mag > lim) mag = lim;
    return neg ? SPREAD_W'(-mag) : mag[SPREAD_W-1:0];
  endfunction

  function automatic spread_result_t grid_spread();
    spread_result_t             r;
    logic signed [WORK_W-1:0]   m;
    logic signed [WORK_W-1:0]   s1;
    logic signed [WORK_W-1:0]   s2;
    logic signed [WORK_W-1:0]   num;
    logic        [WORK_W-1:0]   mag;
    logic        [WORK_W-1:0]   quo;
    logic                       neg;
    r  = '0;
    m  = $signed(mass_acc);
    s1 = $signed(first_acc);
    s2 = $signed(second_acc);
    if (axis_sel == AXIS_BAD) begin
      r.spread   = MINUS_ONE;
      r.bad_axis = 1'b1;
    end else if (m <= 0) begin
      neg       = s2 < 0;
      mag       = neg ? -s2 : s2;
      mag       = mag << (OUT_FRAC - (VALUE_BITS - 4));
      r.spread  = saturate(neg, mag);
      r.no_mass = 1'b1;
    end else begin
      num      = s2 * m - s1 * s1;
      neg      = num < 0;
      mag      = neg ? -num : num;
      quo      = (mag << OUT_FRAC) / (m * m);
      r.spread = saturate(neg, quo);
    end
    return r;
  endfunction

  task automatic take_node();
    logic signed [VALUE_BITS-1:0] v;
    logic signed [63:0]           v64;
    logic signed [63:0]           p64;
    int                           pos;
    v   = s_axis_tdata[VALUE_BITS-1:0];
    v64 = v;
    case (axis_sel)
      AXIS_I:  pos = pos_i;
      AXIS_J:  pos = pos_j;
      AXIS_K:  pos = pos_k;
      default: pos = 0;
    endcase
    p64 = pos;
    if (!s_axis_tuser[0]) begin
      mass_acc   = mass_acc + v64[MASS_W-1:0];
      first_acc  = first_acc + FIRST_W'(v64 * p64);
      second_acc = second_acc + SECOND_W'(v64 * p64 * p64);
    end
    pos_k++;
    if (pos_k >= extent(size_k)) begin
      pos_k = 0;
      pos_j++;
      if (pos_j >= extent(size_j)) begin
        pos_j = 0;
        pos_i++;
        if (pos_i >= extent(size_i)) pos_i = 0;
      end
    end
    if (s_axis_tlast) begin
      spread_due.push_back(grid_spread());
      clear_grid();
    end
  endtask

  task automatic report(string field, logic [SPREAD_W-1:0] want, logic [SPREAD_W-1:0] got);
    fails++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  task automatic compare_result();
    spread_result_t want;
    if (spread_due.size() == 0) begin
      fails++;
      $display("%0t: result beat with nothing expected, actual spread %h flags %b",
               $time, m_axis_tdata, m_axis_tuser);
    end else begin
      want = spread_due.pop_front();
      checked++;
      if (m_axis_tdata !== want.spread) report("spread", want.spread, m_axis_tdata);
      if (m_axis_tuser[0] !== want.bad_axis) report("bad_axis", want.bad_axis, m_axis_tuser[0]);
      if (m_axis_tuser[1] !== want.no_mass) report("no_mass", want.no_mass, m_axis_tuser[1]);
      if (want.no_mass) no_mass_seen++;
      if (want.bad_axis) bad_axis_seen++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      size_i   = SIZE_RESET;
      size_j   = SIZE_RESET;
      size_k   = SIZE_RESET;
      axis_sel = AXIS_I;
      clear_grid();
      spread_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) compare_result();
      if (s_axis_tvalid && s_axis_tready) take_node();
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_SIZE_I: size_i = cfg_data;
          CFG_SIZE_J: size_j = cfg_data;
          CFG_SIZE_K: size_k = cfg_data;
          default:    axis_sel = axis_t'(cfg_data[AXIS_W-1:0]);
        endcase
      end
    end
    waiting = spread_due.size();
  end

endmodule

[sim/tb_masked_axis_spread_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Masked axis spread unit testbench
// Streams directed and random grids of nodes into the unit under a series of
// register settings, with random gaps on both sides and one long result
// stall. A separate checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_masked_axis_spread_unit;
  import masp_pkg::*;

  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_WAIT   = 400;
  localparam int HOLD_CYCLES  = 1500;
  localparam int RANDOM_NODES = 950;
  localparam int BIG_ROOM     = 2 * MAX_EDGE_DEF + 3;

  localparam logic [23:0] VAL_MAX = 24'h7fffff;
  localparam logic [23:0] VAL_MIN = 24'h800000;

  typedef enum int {
    FILL_FULL,
    FILL_SMALL_POS,
    FILL_NEG,
    FILL_EXTREME,
    FILL_MIXED
  } fill_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_reg_t            cfg_index;
  logic [SIZE_W-1:0]   cfg_data;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                s_axis_tlast;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [SPREAD_W-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int fails;
  int waiting;
  int checked;
  int no_mass_seen;
  int bad_axis_seen;
  int nodes_sent;
  int grids_sent;
  int settings_used;
  int idle_cycles;
  bit tx_eager;
  bit hold_request;

  masked_axis_spread_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  masp_spread_checker spread_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fails         (fails),
    .waiting       (waiting),
    .checked       (checked),
    .no_mass_seen  (no_mass_seen),
    .bad_axis_seen (bad_axis_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("[masked_axis_spread_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    int beats;
    bit rx_eager;
    m_axis_tready = 1'b0;
    beats         = 0;
    rx_eager      = 1'b0;
    @(negedge clk);
    forever begin
      if (beats % 16 == 0) rx_eager = $urandom_range(0, 2) == 0;
      if (hold_request) begin
        hold_request  = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = rx_eager ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        m_axis_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      beats++;
      @(negedge clk);
    end
  end

  function automatic logic [23:0] pick_value(fill_t f);
    case (f)
      FILL_SMALL_POS: return 24'($urandom_range(1, 1 << 20));
      FILL_NEG:       return -24'($urandom_range(1, 1 << 23));
      FILL_MIXED:     return 24'(int'($urandom_range(0, 8191)) - 4096);
      FILL_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return 24'h000000;
          3:       return 24'hffffff;
          default: return 24'h000001;
        endcase
      end
      default:        return 24'($urandom);
    endcase
  endfunction

  task automatic send_node(logic [23:0] value, bit solid, bit is_last);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 12);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = value;
    s_axis_tuser  = solid;
    s_axis_tlast  = is_last;
    do @(posedge clk); while (!s_axis_tready);
    nodes_sent++;
  endtask

  task automatic send_grid(int nodes, bit broken, fill_t f, int solid_pct);
    int count;
    count    = broken ? $urandom_range(1, 2 * nodes + 3) : nodes;
    tx_eager = $urandom_range(0, 2) == 0;
    for (int n = 0; n < count; n++) begin
      send_node(pick_value(f), $urandom_range(0, 99) < solid_pct, n == count - 1);
    end
    grids_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(logic [SIZE_W-1:0] si, logic [SIZE_W-1:0] sj,
                               logic [SIZE_W-1:0] sk, axis_t ax);
    settle();
    write_reg(CFG_SIZE_I, si);
    write_reg(CFG_SIZE_J, sj);
    write_reg(CFG_SIZE_K, sk);
    write_reg(CFG_AXIS, SIZE_W'(ax));
    settings_used++;
  endtask

  initial begin
    int                random_start;
    int                phase;
    int                dim;
    int                big;
    int                nodes;
    int                grids;
    int                solid_pct;
    bit                go_big;
    logic [SIZE_W-1:0] sz[3];
    axis_t             ax;
    rst           = 1'b1;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_SIZE_I;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    s_axis_tlast  = 1'b0;
    tx_eager      = 1'b0;
    hold_request  = 1'b0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    apply_setting(SIZE_W'(1), SIZE_W'(1), SIZE_W'(4), AXIS_K);
    send_node(VAL_MAX, 1'b0, 1'b0);
    send_node(24'h000001, 1'b0, 1'b0);
    send_node(24'h000000, 1'b0, 1'b0);
    send_node(VAL_MAX, 1'b0, 1'b1);
    send_node(24'h000001, 1'b0, 1'b0);
    send_node(24'h400000, 1'b0, 1'b0);
    send_node(VAL_MIN, 1'b0, 1'b0);
    send_node(24'h400000, 1'b0, 1'b1);
    send_node(VAL_MIN + 24'd2, 1'b0, 1'b0);
    send_node(VAL_MIN, 1'b1, 1'b0);
    send_node(VAL_MIN, 1'b1, 1'b0);
    send_node(VAL_MAX, 1'b0, 1'b1);
    send_node(VAL_MAX, 1'b1, 1'b1);
    send_node(VAL_MAX, 1'b1, 1'b0);
    send_node(VAL_MIN, 1'b0, 1'b1);
    apply_setting('0, '0, '0, AXIS_BAD);
    send_node(VAL_MIN, 1'b0, 1'b1);
    apply_setting('0, '0, '0, AXIS_I);
    send_node(VAL_MAX, 1'b0, 1'b0);
    send_node(VAL_MAX, 1'b0, 1'b1);
    grids_sent += 7;

    random_start = nodes_sent;
    phase        = 0;
    while (nodes_sent - random_start < RANDOM_NODES || phase < 6) begin
      go_big = (phase != 5) && (nodes_sent - random_start < RANDOM_NODES - BIG_ROOM) &&
               ($urandom_range(0, 15) == 0);
      if (phase == 2 || go_big) begin
        dim = $urandom_range(0, 2);
        case ($urandom_range(0, 2))
          0:       big = 256;
          1:       big = 511;
          default: big = $urandom_range(200, 300);
        endcase
        foreach (sz[d]) sz[d] = SIZE_W'($urandom_range(0, 1));
        sz[dim] = SIZE_W'(big);
        nodes   = (big > MAX_EDGE_DEF) ? MAX_EDGE_DEF : big;
        apply_setting(sz[0], sz[1], sz[2], axis_t'(dim));
        if (phase == 2) begin
          send_grid(nodes, 1'b0, FILL_NEG, 0);
        end else begin
          send_grid(nodes, $urandom_range(0, 5) == 0, fill_t'($urandom_range(0, 4)),
                    $urandom_range(0, 30));
        end
      end else begin
        ax = ($urandom_range(0, 7) == 0) ? AXIS_BAD : axis_t'($urandom_range(0, 2));
        foreach (sz[d]) sz[d] = SIZE_W'($urandom_range(0, 4));
        if (phase == 5) begin
          foreach (sz[d]) sz[d] = SIZE_W'(1);
        end
        nodes = 1;
        foreach (sz[d]) nodes *= (sz[d] == 0) ? 1 : int'(sz[d]);
        apply_setting(sz[0], sz[1], sz[2], ax);
        grids = $urandom_range(3, 8);
        if (phase == 5) begin
          hold_request = 1'b1;
          grids        = 12;
        end
        repeat (grids) begin
          if ($urandom_range(0, 9) == 0) begin
            solid_pct = 100;
          end else begin
            solid_pct = $urandom_range(0, 1) ? 25 : 0;
          end
          send_grid(nodes, $urandom_range(0, 6) == 0, fill_t'($urandom_range(0, 4)),
                    solid_pct);
        end
      end
      phase++;
    end

    settle();
    $display("Summary: %0d nodes in %0d grids under %0d register settings, %0d results checked.",
             nodes_sent, grids_sent, settings_used, checked);
    $display("Results with no positive mass: %0d, with an unrecognized axis: %0d.",
             no_mass_seen, bad_axis_seen);
    if (fails == 0 && waiting == 0) begin
      $display("[masked_axis_spread_unit] OK");
    end else begin
      $display("[masked_axis_spread_unit] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/masp_pkg.sv
rtl/masp_front.sv
rtl/masp_queue.sv
rtl/masp_back.sv
rtl/masked_axis_spread_unit.sv
sim/masp_spread_checker.sv
sim/tb_masked_axis_spread_unit.sv
